// File: hw/rtl/fixed_point_square_root_q4_12_assert.svh
// Assertion macros for the Q4.12 square root checker.
// Standalone header; expects clk and arst_n in the scope of use.
`ifndef FIXED_POINT_SQUARE_ROOT_Q4_12_ASSERT_SVH
`define FIXED_POINT_SQUARE_ROOT_Q4_12_ASSERT_SVH

// same-cycle implication
`define FPSQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpsq assertion failed");

// next-cycle implication
`define FPSQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpsq assertion failed");

`endif

// File: hw/rtl/fpsq_pkg.sv
// Package for the Q4.12 square root: root sample table, stage types and
// the byte leading-zero function. No dependencies.
package fpsq_pkg;

	localparam int unsigned TAB_DEPTH = 193;

	typedef logic [16:0] tab_word_t;

	// sqrt(k/128) * 2^16 for k = 64..256
	localparam tab_word_t ROOT_TAB [TAB_DEPTH] = '{
		17'd46341, 17'd46702, 17'd47059, 17'd47415, 17'd47767, 17'd48117, 17'd48465,
		17'd48809, 17'd49152, 17'd49492, 17'd49830, 17'd50166, 17'd50499, 17'd50830,
		17'd51159, 17'd51486, 17'd51811, 17'd52134, 17'd52454, 17'd52773, 17'd53090,
		17'd53405, 17'd53719, 17'd54030, 17'd54340, 17'd54647, 17'd54954, 17'd55258,
		17'd55561, 17'd55862, 17'd56162, 17'd56459, 17'd56756, 17'd57051, 17'd57344,
		17'd57636, 17'd57926, 17'd58215, 17'd58503, 17'd58789, 17'd59073, 17'd59357,
		17'd59639, 17'd59919, 17'd60199, 17'd60477, 17'd60753, 17'd61029, 17'd61303,
		17'd61576, 17'd61848, 17'd62119, 17'd62388, 17'd62657, 17'd62924, 17'd63190,
		17'd63455, 17'd63719, 17'd63982, 17'd64243, 17'd64504, 17'd64763, 17'd65022,
		17'd65279, 17'd65536, 17'd65792, 17'd66046, 17'd66300, 17'd66552, 17'd66804,
		17'd67054, 17'd67304, 17'd67553, 17'd67801, 17'd68048, 17'd68294, 17'd68539,
		17'd68784, 17'd69027, 17'd69270, 17'd69511, 17'd69752, 17'd69992, 17'd70232,
		17'd70470, 17'd70708, 17'd70945, 17'd71181, 17'd71416, 17'd71651, 17'd71885,
		17'd72118, 17'd72350, 17'd72581, 17'd72812, 17'd73042, 17'd73271, 17'd73500,
		17'd73728, 17'd73955, 17'd74182, 17'd74408, 17'd74633, 17'd74857, 17'd75081,
		17'd75304, 17'd75527, 17'd75748, 17'd75969, 17'd76190, 17'd76410, 17'd76629,
		17'd76848, 17'd77066, 17'd77283, 17'd77500, 17'd77716, 17'd77932, 17'd78147,
		17'd78361, 17'd78575, 17'd78788, 17'd79001, 17'd79213, 17'd79424, 17'd79635,
		17'd79846, 17'd80056, 17'd80265, 17'd80474, 17'd80682, 17'd80890, 17'd81097,
		17'd81303, 17'd81509, 17'd81715, 17'd81920, 17'd82125, 17'd82329, 17'd82532,
		17'd82735, 17'd82938, 17'd83140, 17'd83341, 17'd83542, 17'd83743, 17'd83943,
		17'd84143, 17'd84342, 17'd84540, 17'd84739, 17'd84936, 17'd85134, 17'd85331,
		17'd85527, 17'd85723, 17'd85918, 17'd86113, 17'd86308, 17'd86502, 17'd86696,
		17'd86889, 17'd87082, 17'd87275, 17'd87467, 17'd87658, 17'd87849, 17'd88040,
		17'd88231, 17'd88420, 17'd88610, 17'd88799, 17'd88988, 17'd89176, 17'd89364,
		17'd89552, 17'd89739, 17'd89926, 17'd90112, 17'd90298, 17'd90484, 17'd90669,
		17'd90854, 17'd91038, 17'd91222, 17'd91406, 17'd91589, 17'd91772, 17'd91955,
		17'd92137, 17'd92319, 17'd92501, 17'd92682
	};

	localparam logic [7:0] TAB_BASE_HI = 8'd64;

	// normalized operand
	typedef struct packed {
		logic              zero;
		logic signed [3:0] expo;
		logic [15:0]       frac;
	} norm_t;

	// stage load enables
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	function automatic logic [3:0] lz8(input logic [7:0] b);
		logic [3:0] n;
		logic       found;
		n = 4'd8;
		found = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!found && b[i]) begin
				n = 4'(7 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// File: hw/rtl/fixed_point_square_root_q4_12.sv
// Q4.12 square root, table lookup with linear interpolation.
// Depends on fpsq_pkg, fpsq_norm, fpsq_lerp and fpsq_scale.
//
// Takes one request per clock while value_stall is low and returns root =
// sqrt(value) in unsigned Q3.12, rounded to nearest (zero gives zero, 65535
// gives 16384). An accepted request passes through normalize, table lookup,
// interpolation multiply-add, then shift and round into the output register.
// Each stage holds its own valid bit and only stalls when it is full and the
// stage after it cannot take its item, so bubbles close up and value_stall
// rises only when all four stages are full and stalled.
module fixed_point_square_root_q4_12 import fpsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        value_valid,
	output logic        value_stall,
	input  logic [15:0] value,
	output logic        root_valid,
	input  logic        root_stall,
	output logic [14:0] root
);

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              rdy1;
	logic              rdy2;
	logic              rdy3;
	logic              rdy4;
	stage_en_t         en;
	norm_t             nrm;
	norm_t             nrm_s1;
	logic [24:0]       acc_s3;
	logic signed [3:0] expo_s3;
	logic              zero_s3;
	logic [14:0]       root_nxt;
	logic [14:0]       root_s4;

	always_comb begin
		rdy4  = !valid_s4 || !root_stall;
		rdy3  = !valid_s3 || rdy4;
		rdy2  = !valid_s2 || rdy3;
		rdy1  = !valid_s1 || rdy2;
		en.s2 = rdy2;
		en.s3 = rdy3;
	end

	assign value_stall = !rdy1;
	assign root_valid  = valid_s4;
	assign root        = root_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= value_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	fpsq_norm u_norm (
		.value (value),
		.nrm   (nrm)
	);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			nrm_s1 <= nrm;
		end
	end

	fpsq_lerp u_lerp (
		.clk     (clk),
		.en      (en),
		.nrm_s1  (nrm_s1),
		.acc_s3  (acc_s3),
		.expo_s3 (expo_s3),
		.zero_s3 (zero_s3)
	);

	fpsq_scale u_scale (
		.acc  (acc_s3),
		.expo (expo_s3),
		.zero (zero_s3),
		.root (root_nxt)
	);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			root_s4 <= root_nxt;
		end
	end

endmodule

// File: hw/rtl/fpsq_norm.sv
// Normalizer: two byte-wise leading-zero steps, parity shift, exponent.
// Depends on fpsq_pkg.
module fpsq_norm import fpsq_pkg::*; (
	input  logic [15:0] value,
	output norm_t       nrm
);

	logic [3:0]        s1;
	logic [3:0]        s2;
	logic [15:0]       w1;
	logic [15:0]       w2;
	logic [4:0]        total;
	logic              odd;
	logic signed [5:0] e2;

	always_comb begin
		s1    = lz8(value[15:8]);
		w1    = value << s1;
		s2    = lz8(w1[15:8]);
		w2    = w1 << s2;
		total = 5'(s1) + 5'(s2);
		odd   = ~total[0];
		e2    = 6'sd3 + signed'({5'd0, odd}) - signed'({1'b0, total});
		nrm.zero = (value == 16'd0);
		nrm.expo = signed'(e2[4:1]);
		nrm.frac = w2 >> odd;
	end

endmodule

// File: hw/rtl/fpsq_lerp.sv
// Table lookup stage and interpolation multiply-add stage.
// Depends on fpsq_pkg (root table, norm_t, stage_en_t).
module fpsq_lerp import fpsq_pkg::*; (
	input  logic              clk,
	input  stage_en_t         en,
	input  norm_t             nrm_s1,
	output logic [24:0]       acc_s3,
	output logic signed [3:0] expo_s3,
	output logic              zero_s3
);

	logic [7:0]        idx;
	logic [7:0]        idx_nxt;
	tab_word_t         base;
	tab_word_t         nxt;
	logic [16:0]       base_s2;
	logic [8:0]        step_s2;
	logic [7:0]        lo_s2;
	logic signed [3:0] expo_s2;
	logic              zero_s2;
	logic [16:0]       prod;

	always_comb begin
		idx     = nrm_s1.frac[15:8] - TAB_BASE_HI;
		idx_nxt = idx + 8'd1;
		base    = ROOT_TAB[idx];
		nxt     = ROOT_TAB[idx_nxt];
		prod    = 17'(lo_s2 * step_s2);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			base_s2 <= base;
			step_s2 <= 9'(nxt - base);
			lo_s2   <= nrm_s1.frac[7:0];
			expo_s2 <= nrm_s1.expo;
			zero_s2 <= nrm_s1.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			acc_s3  <= {base_s2, 8'd0} + 25'(prod);
			expo_s3 <= expo_s2;
			zero_s3 <= zero_s2;
		end
	end

endmodule

// File: hw/rtl/fpsq_scale.sv
// Denormalize by half the exponent and round to nearest Q3.12.
// Depends on fpsq_pkg only through the import convention.
module fpsq_scale import fpsq_pkg::*; (
	input  logic [24:0]       acc,
	input  logic signed [3:0] expo,
	input  logic              zero,
	output logic [14:0]       root
);

	logic [26:0] wide;
	logic [26:0] sh;
	logic [3:0]  mag;
	logic [16:0] rnd;

	always_comb begin
		wide = {2'b00, acc};
		mag  = 4'(-expo);
		if (expo >= 4'sd0) begin
			sh = wide << expo[1:0];
		end else begin
			sh = wide >> mag[2:0];
		end
		rnd  = {1'b0, sh[26:11]} + 17'd1;
		root = zero ? 15'd0 : rnd[15:1];
	end

endmodule

// File: hw/rtl/fpsq_checker.sv
// Port-level checker for the Q4.12 square root, bound to the top level.
// Depends on fixed_point_square_root_q4_12_assert.svh.
`include "fixed_point_square_root_q4_12_assert.svh"

module fpsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        value_valid,
	input logic        value_stall,
	input logic [15:0] value,
	input logic        root_valid,
	input logic        root_stall,
	input logic [14:0] root
);

	// input side only backs up when the output is full and stalled
	`FPSQ_ASSERT_IMP(a_stall_source, value_stall, root_valid && root_stall)

	`FPSQ_ASSERT_NXT(a_root_hold, root_valid && root_stall, root_valid && $stable(root))

	`FPSQ_ASSERT_IMP(a_root_range, root_valid, root <= 15'd16384)

	// zero request with a free-running output later shows up as a valid zero root
	`FPSQ_ASSERT_NXT(a_zero_latency, (value_valid && !value_stall && value == 16'd0) ##1 !root_stall ##1 !root_stall ##1 !root_stall, root_valid && root == 15'd0)

endmodule

bind fixed_point_square_root_q4_12 fpsq_checker u_fpsq_checker (.*);
